// ----- rtl/core/ibspt_pkg.sv -----
package ibspt_pkg;

  // Field and datapath widths.
  localparam int IN_W  = 16;
  localparam int VAL_W = 20;
  localparam int SUM_W = 24;
  localparam int REM_W = SUM_W + 1;
  localparam int Q_W   = 16;
  localparam int ROWS  = 9;

  localparam logic [IN_W-1:0] ONE_Q15 = 16'h8000;

  typedef logic [VAL_W-1:0] val_t;

  // Operand codes for the factor multiplexers.
  typedef enum logic [3:0] {
    OP_ZERO, OP_P, OP_Q,
    OP_P0, OP_P1, OP_P2, OP_P3,
    OP_Q0, OP_Q1, OP_Q2, OP_Q3
  } opnd_t;

  // Factor selection for one genotype-pair row.
  typedef struct packed {
    opnd_t       a;
    opnd_t       b;
    opnd_t       c;
    opnd_t       d;
    logic [1:0]  k0;
    opnd_t       xa;
    opnd_t       ya;
    opnd_t       za;
    opnd_t       xb;
    opnd_t       yb;
    opnd_t       zb;
    opnd_t       u;
    opnd_t       w;
    logic [1:0]  k2;
  } row_ops_t;

  typedef struct packed {
    logic                  v;
    logic                  last;
    logic [2:0][VAL_W-1:0] num;
  } num_row_t;

  typedef struct packed {
    logic [3:0] combo;
    logic       last;
  } div_tag_t;

  typedef struct packed {
    logic                  v;
    div_tag_t              tag;
    logic [2:0][VAL_W-1:0] num;
    logic [2:0][SUM_W-1:0] sum;
  } div_in_t;

  typedef struct packed {
    logic                v;
    div_tag_t            tag;
    logic [2:0][Q_W-1:0] quot;
  } div_out_t;

  // Q15 product, truncated.
  function automatic val_t mq(val_t a, val_t b);
    logic [2*VAL_W-1:0] pr;
    pr = a * b;
    return pr[VAL_W+14:15];
  endfunction

  // Factors of each row; a zero first factor makes that entry zero.
  function automatic row_ops_t row_ops(logic [3:0] r);
    row_ops_t o;
    o = '0;
    unique case (r)
      4'd0: begin
        o.a = OP_P1; o.b = OP_P0; o.c = OP_Q1; o.d = OP_Q0;
      end
      4'd1: begin
        o.a = OP_Q1; o.b = OP_Q0; o.c = OP_P1; o.d = OP_P0;
      end
      4'd2: begin
        o.a = OP_P2; o.b = OP_P1; o.c = OP_P0; o.d = OP_Q0; o.k0 = 2'd1;
        o.xa = OP_P; o.ya = OP_P1; o.za = OP_Q0;
      end
      4'd3: begin
        o.a = OP_P2; o.b = OP_P1; o.c = OP_P0; o.d = OP_Q0; o.k0 = 2'd1;
        o.xa = OP_P; o.ya = OP_Q0; o.za = OP_P1;
      end
      4'd4: begin
        o.a = OP_Q2; o.b = OP_Q1; o.c = OP_Q0; o.d = OP_P0; o.k0 = 2'd1;
        o.xa = OP_Q; o.ya = OP_P0; o.za = OP_Q1;
      end
      4'd5: begin
        o.a = OP_Q2; o.b = OP_Q1; o.c = OP_Q0; o.d = OP_P0; o.k0 = 2'd1;
        o.xa = OP_Q; o.ya = OP_Q1; o.za = OP_P0;
      end
      4'd6: begin
        o.a = OP_P3; o.b = OP_P2; o.c = OP_P1; o.d = OP_P0;
        o.xa = OP_P; o.ya = OP_P1; o.za = OP_P1;
        o.u = OP_P1; o.w = OP_P0;
      end
      4'd7: begin
        o.a = OP_P1; o.b = OP_P0; o.c = OP_Q1; o.d = OP_Q0; o.k0 = 2'd2;
        o.xa = OP_P; o.ya = OP_Q0; o.za = OP_Q0;
        o.xb = OP_Q; o.yb = OP_P0; o.zb = OP_P0;
        o.u = OP_P0; o.w = OP_Q1; o.k2 = 2'd1;
      end
      4'd8: begin
        o.a = OP_Q3; o.b = OP_Q2; o.c = OP_Q1; o.d = OP_Q0;
        o.xa = OP_Q; o.ya = OP_Q1; o.za = OP_Q1;
        o.u = OP_Q1; o.w = OP_Q0;
      end
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/core/ibs_ibd_probability_table_unit.sv -----
// Throughput: one result row per cycle while out_ready is high; a new transaction waits
// in the input register while the rows of the previous one issue. The single row lane of
// the multiply pipeline and the result channel each carry 9 rows per transaction.
// The normalizing divider is a 16-stage pipeline with one quotient bit per stage.
// Reset (rst, synchronous) clears all valid bits, the row sequencer and the column sums.
module ibs_ibd_probability_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] allele_freq,
  input  logic [15:0] coancestry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  combo,
  output logic [15:0] prob_ibd0,
  output logic [15:0] prob_ibd1,
  output logic [15:0] prob_ibd2,
  output logic        last
);
  import ibspt_pkg::*;

  num_row_t row;
  div_in_t  din;
  div_out_t dout;
  logic     en, den;

  // The divider advances unless a result waits at the output.
  assign den = !dout.v || out_ready;

  ibspt_rowgen u_rowgen (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .allele_freq (allele_freq),
    .coancestry  (coancestry),
    .en          (en),
    .row         (row)
  );

  ibspt_collect u_collect (
    .clk (clk),
    .rst (rst),
    .row (row),
    .den (den),
    .en  (en),
    .din (din)
  );

  ibspt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (den),
    .din  (din),
    .dout (dout)
  );

  assign out_valid = dout.v;
  assign combo     = dout.tag.combo;
  assign last      = dout.tag.last;
  assign prob_ibd0 = dout.quot[0];
  assign prob_ibd1 = dout.quot[1];
  assign prob_ibd2 = dout.quot[2];

endmodule

// ----- rtl/core/ibspt_rowgen.sv -----
module ibspt_rowgen (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              allele_freq,
  input  logic [15:0]              coancestry,
  input  logic                     en,
  output ibspt_pkg::num_row_t      row
);
  import ibspt_pkg::*;

  logic                  a_v;
  logic [IN_W-1:0]       a_p, a_f, p_sat, f_sat, q_a, omf;
  logic [2*IN_W-1:0]     pa_pr, qa_pr;
  val_t                  pa, qa, fv;
  logic [10:0][VAL_W-1:0] ov, ov_next;
  logic                  b_v, b_free;
  logic [3:0]            rc;
  row_ops_t              ops;

  logic       s1_v, s1_last;
  val_t       s1_m0, s1_c, s1_d, s1_la, s1_za, s1_lb, s1_zb, s1_c2;
  logic [1:0] s1_k0, s1_k2;
  logic       s2_v, s2_last;
  val_t       s2_m0, s2_d, s2_la, s2_lb, s2_c2;
  logic [1:0] s2_k0, s2_k2;
  val_t       m3;

  // Inputs above one saturate to one.
  assign p_sat = (allele_freq > ONE_Q15) ? ONE_Q15 : allele_freq;
  assign f_sat = (coancestry > ONE_Q15) ? ONE_Q15 : coancestry;

  assign b_free   = !b_v || (en && rc == 4'(ROWS - 1));
  assign in_ready = !a_v || b_free;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (in_ready) begin
      a_v <= in_valid;
    end
    if (in_ready && in_valid) begin
      a_p <= p_sat;
      a_f <= f_sat;
    end
  end

  // Terms M(f,i) = (1-F)f + iF for f = p and f = q.
  always_comb begin
    q_a   = ONE_Q15 - a_p;
    omf   = ONE_Q15 - a_f;
    pa_pr = omf * a_p;
    qa_pr = omf * q_a;
    pa    = VAL_W'(pa_pr[2*IN_W-1:15]);
    qa    = VAL_W'(qa_pr[2*IN_W-1:15]);
    fv    = VAL_W'(a_f);
    ov_next          = '0;
    ov_next[OP_ZERO] = '0;
    ov_next[OP_P]    = VAL_W'(a_p);
    ov_next[OP_Q]    = VAL_W'(q_a);
    ov_next[OP_P0]   = pa;
    ov_next[OP_P1]   = pa + fv;
    ov_next[OP_P2]   = pa + (fv << 1);
    ov_next[OP_P3]   = pa + fv + (fv << 1);
    ov_next[OP_Q0]   = qa;
    ov_next[OP_Q1]   = qa + fv;
    ov_next[OP_Q2]   = qa + (fv << 1);
    ov_next[OP_Q3]   = qa + fv + (fv << 1);
  end

  // Term register and row sequencer: one row issued per enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      rc  <= '0;
    end else if (b_free) begin
      b_v <= a_v;
      rc  <= '0;
    end else if (en) begin
      rc <= rc + 4'd1;
    end
    if (b_free) begin
      ov <= ov_next;
    end
  end

  assign ops = row_ops(rc);

  // Multiply stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      row.v <= 1'b0;
    end else if (en) begin
      s1_v  <= b_v;
      s2_v  <= s1_v;
      row.v <= s2_v;
    end
    if (en) begin
      s1_last <= (rc == 4'(ROWS - 1));
      s1_m0   <= mq(ov[ops.a], ov[ops.b]);
      s1_c    <= ov[ops.c];
      s1_d    <= ov[ops.d];
      s1_la   <= mq(ov[ops.xa], ov[ops.ya]);
      s1_za   <= ov[ops.za];
      s1_lb   <= mq(ov[ops.xb], ov[ops.yb]);
      s1_zb   <= ov[ops.zb];
      s1_c2   <= mq(ov[ops.u], ov[ops.w]);
      s1_k0   <= ops.k0;
      s1_k2   <= ops.k2;

      s2_last <= s1_last;
      s2_m0   <= mq(s1_m0, s1_c);
      s2_d    <= s1_d;
      s2_la   <= mq(s1_la, s1_za);
      s2_lb   <= mq(s1_lb, s1_zb);
      s2_c2   <= s1_c2;
      s2_k0   <= s1_k0;
      s2_k2   <= s1_k2;

      row.last   <= s2_last;
      row.num[0] <= m3 << s2_k0;
      row.num[1] <= s2_la + s2_lb;
      row.num[2] <= s2_c2 << s2_k2;
    end
  end

  assign m3 = mq(s2_m0, s2_d);

endmodule

// ----- rtl/core/ibspt_collect.sv -----
module ibspt_collect (
  input  logic                 clk,
  input  logic                 rst,
  input  ibspt_pkg::num_row_t  row,
  input  logic                 den,
  output logic                 en,
  output ibspt_pkg::div_in_t   din
);
  import ibspt_pkg::*;

  logic [2:0][VAL_W-1:0] nb [ROWS-1];
  logic [2:0][VAL_W-1:0] hold [ROWS];
  logic [2:0][SUM_W-1:0] acc, acc_fin, hsum;
  logic [3:0]            hcnt;
  logic                  load_ok, consume, load, emit;

  // The hold bank takes a finished column set when it is empty or draining its last row.
  assign load_ok = (hcnt == 4'd0) || (hcnt == 4'd1 && den);
  assign en      = !(row.v && row.last && !load_ok);
  assign consume = en && row.v;
  assign load    = consume && row.last;
  assign emit    = den && (hcnt != 4'd0);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc_fin[j] = acc[j] + SUM_W'(row.num[j]);
    end
  end

  // Column sums and count of rows waiting in the hold bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      hcnt <= '0;
    end else begin
      if (consume) begin
        acc <= row.last ? '0 : acc_fin;
      end
      if (load) begin
        hcnt <= 4'(ROWS);
      end else if (emit) begin
        hcnt <= hcnt - 4'd1;
      end
    end
  end

  // Pending rows of the current transaction, then the hold bank.
  always_ff @(posedge clk) begin
    if (consume && !row.last) begin
      for (int k = 0; k < ROWS - 2; k++) begin
        nb[k] <= nb[k+1];
      end
      nb[ROWS-2] <= row.num;
    end
    if (load) begin
      for (int k = 0; k < ROWS - 1; k++) begin
        hold[k] <= nb[k];
      end
      hold[ROWS-1] <= row.num;
      hsum         <= acc_fin;
    end else if (emit) begin
      for (int k = 0; k < ROWS - 1; k++) begin
        hold[k] <= hold[k+1];
      end
    end
  end

  assign din.v         = (hcnt != 4'd0);
  assign din.tag.combo = 4'(ROWS) - hcnt;
  assign din.tag.last  = (hcnt == 4'd1);
  assign din.num       = hold[0];
  assign din.sum       = hsum;

`ifndef SYNTHESIS
  a_hcnt_range: assert property (@(posedge clk) disable iff (rst) hcnt <= 4'(ROWS))
    else $error("hold count out of range");
  a_stall_only_last: assert property (@(posedge clk) disable iff (rst)
    !en |-> (row.v && row.last))
    else $error("row pipeline stalled without a waiting last row");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (hcnt == 4'd0 || (hcnt == 4'd1 && den)))
    else $error("hold bank overwritten");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> hcnt == 4'(ROWS))
    else $error("hold count not set after load");
`endif

endmodule

// ----- rtl/core/ibspt_div.sv -----
module ibspt_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ibspt_pkg::div_in_t  din,
  output ibspt_pkg::div_out_t dout
);
  import ibspt_pkg::*;

  logic                  sv   [Q_W];
  div_tag_t              stg  [Q_W];
  logic [2:0][REM_W-1:0] srem [Q_W];
  logic [2:0][SUM_W-1:0] sdv  [Q_W];
  logic [2:0][Q_W-1:0]   sq   [Q_W];

  // One quotient bit per stage, three columns side by side.
  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic                  vi;
    div_tag_t              ti;
    logic [2:0][REM_W-1:0] ri, rn, tt;
    logic [2:0][SUM_W-1:0] di;
    logic [2:0][Q_W-1:0]   qi, qn;

    if (k == 0) begin : g_src
      always_comb begin
        vi = din.v;
        ti = din.tag;
        di = din.sum;
        qi = '0;
        for (int j = 0; j < 3; j++) begin
          ri[j] = REM_W'(din.num[j]);
        end
      end
    end else begin : g_src
      always_comb begin
        vi = sv[k-1];
        ti = stg[k-1];
        ri = srem[k-1];
        di = sdv[k-1];
        qi = sq[k-1];
      end
    end

    // The first step tests the integer bit without a shift.
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        if (k == 0) begin
          tt[j] = ri[j];
        end else begin
          tt[j] = {ri[j][REM_W-2:0], 1'b0};
        end
        if (tt[j] >= REM_W'(di[j])) begin
          rn[j] = tt[j] - REM_W'(di[j]);
          qn[j] = {qi[j][Q_W-2:0], 1'b1};
        end else begin
          rn[j] = tt[j];
          qn[j] = {qi[j][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= vi;
      end
      if (en) begin
        stg[k]  <= ti;
        srem[k] <= rn;
        sdv[k]  <= di;
        sq[k]   <= qn;
      end
    end
  end

  // A zero column sum leaves its entries (all zero) unnormalized.
  always_comb begin
    dout.v   = sv[Q_W-1];
    dout.tag = stg[Q_W-1];
    for (int j = 0; j < 3; j++) begin
      dout.quot[j] = (sdv[Q_W-1][j] == '0) ? '0 : sq[Q_W-1][j];
    end
  end

endmodule
